FILE: hdl/matrix4_inverse_gauss_jordan_unit_assert.svh
// Assertion macros shared by the checker of the matrix inverse unit.
`ifndef MATRIX4_INVERSE_GAUSS_JORDAN_UNIT_ASSERT_SVH
`define MATRIX4_INVERSE_GAUSS_JORDAN_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MI4_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MI4_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/mi4_pkg.sv
// Shared constants and types of the matrix inverse unit.
package mi4_pkg;

  localparam int DIM_DEF       = 4;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_W        = 32;

  // Status of the shared divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } mi4_div_stat_t;

endpackage

FILE: hdl/mi4_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mi4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/mi4_div.sv
// Bit-serial signed fixed-point divider with saturation, one quotient bit per cycle.
module mi4_div #(
  parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [mi4_pkg::WORD_W-1:0] num,
  input  logic signed [mi4_pkg::WORD_W-1:0] den,
  output mi4_pkg::mi4_div_stat_t        stat,
  output logic signed [mi4_pkg::WORD_W-1:0] quot
);

  localparam int W  = mi4_pkg::WORD_W;
  localparam int NW = W + FRAC_BITS;
  localparam int CNW = $clog2(NW + 1);

  logic [NW-1:0]  dvd_r, dvd_nxt;
  logic [W-1:0]   rem_r, rem_nxt, dmag_r, dmag_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           neg_r, neg_nxt;
  logic           busy_r, busy_nxt, done_r, done_nxt;

  logic [W-1:0]   num_mag, den_mag;
  logic [W:0]     rem_sh;
  logic [NW:0]    q_ext;

  assign num_mag = num[W-1] ? W'(-num) : W'(num);
  assign den_mag = den[W-1] ? W'(-den) : W'(den);
  assign rem_sh  = {rem_r, dvd_r[NW-1]};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dmag_nxt = dmag_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = {num_mag, {FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
      dmag_nxt = den_mag;
      cnt_nxt  = '0;
      neg_nxt  = num[W-1] ^ den[W-1];
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Restoring step: the quotient bit enters at the bottom of the dividend.
      if (rem_sh >= {1'b0, dmag_r}) begin
        rem_nxt = W'(rem_sh - {1'b0, dmag_r});
        dvd_nxt = {dvd_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[W-1:0];
        dvd_nxt = {dvd_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    dmag_r <= dmag_nxt;
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
  end

  // Apply the sign to the magnitude and clamp to the word range.
  assign q_ext = {1'b0, dvd_r};
  always_comb begin
    if (neg_r) begin
      if (q_ext > (NW+1)'(64'h8000_0000)) begin
        quot = {1'b1, {(W-1){1'b0}}};
      end else begin
        quot = W'(-q_ext);
      end
    end else begin
      if (q_ext > (NW+1)'(64'h7FFF_FFFF)) begin
        quot = {1'b0, {(W-1){1'b1}}};
      end else begin
        quot = W'(q_ext);
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: hdl/matrix4_inverse_gauss_jordan_unit.sv
// Top level of the DIM x DIM fixed-point matrix inverse unit (Gauss-Jordan).
//
// Usage: the input stream carries one matrix entry per word, signed with
// FRAC_BITS fraction bits, in row-major order; in_tlast marks the last entry
// and starts the inversion. in_tready is high only while the unit loads, so
// one matrix is worked at a time. Extra unflagged words overwrite the last
// slot; an early flagged word starts the inversion with the slots not loaded
// keeping their previous contents.
// The result stream then carries the DIM*DIM inverse entries, row-major,
// saturated, with out_tlast on the final one. out_tuser is the singular flag:
// when a zero pivot is met every result word is zero and the flag is set.
// Loading accepts one word per cycle. The inversion is run by one
// sequencer around a shared bit-serial divider (2*DIM*DIM divisions) and
// one registered multiplier (each multiply-subtract reads the single RAM
// port twice). The default setting is a 4x4 matrix in Q16.16. Each result
// word is read from the RAM only after the previous one has been taken.
// A stalled receiver simply holds the current result word in the output
// register. Reset returns the unit to loading with the load position at zero.
module matrix4_inverse_gauss_jordan_unit #(
  parameter int DIM       = mi4_pkg::DIM_DEF,
  parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] element_value
  input  logic        in_tlast,   // last_element
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_value
  output logic        out_tlast,  // last_result
  output logic        out_tuser   // [0] singular
);

  localparam int W     = mi4_pkg::WORD_W;
  localparam int NCOLS = 2 * DIM;
  localparam int DEPTH = DIM * NCOLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(DIM);
  localparam int CW    = $clog2(NCOLS);
  localparam logic [IW-1:0] LAST_I = IW'(DIM - 1);
  localparam logic [CW-1:0] LAST_C = CW'(NCOLS - 1);

  typedef enum logic [16:0] {
    S_LOAD    = 17'h00001,
    S_IDENT   = 17'h00002,
    S_PIV_RD  = 17'h00004,
    S_PIV_WT  = 17'h00008,
    S_DIV_RD  = 17'h00010,
    S_DIV_WT  = 17'h00020,
    S_DIV_RUN = 17'h00040,
    S_K_RD    = 17'h00080,
    S_K_WT    = 17'h00100,
    S_V_RD    = 17'h00200,
    S_A_RD    = 17'h00400,
    S_A_WT    = 17'h00800,
    S_MS_WR   = 17'h01000,
    S_OUT_RD  = 17'h02000,
    S_OUT_WT  = 17'h04000,
    S_OUT     = 17'h08000,
    S_SPARE   = 17'h10000
  } state_t;

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] row,
                                              input logic [CW-1:0] col);
    logic [AW-1:0] base;
    base = AW'(AW'(row) * AW'(NCOLS));
    return base + AW'(col);
  endfunction

  state_t        state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt, r_r, r_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic          back_r, back_nxt;
  logic [IW-1:0] ld_row_r, ld_row_nxt, ld_col_r, ld_col_nxt;
  logic [IW-1:0] orow_r, orow_nxt, ocol_r, ocol_nxt;
  logic          sing_r, sing_nxt;
  logic          out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;

  logic signed [W-1:0]   p_r, k_r, v_r, a_r, out_data_r;
  logic signed [2*W-1:0] prod_r;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [W-1:0]        ram_wdata, ram_rdata;

  logic                   div_start;
  mi4_pkg::mi4_div_stat_t div_stat;
  logic signed [W-1:0]    div_quot;

  logic signed [2*W-1:0] prod_sh;
  logic signed [2*W:0]   diff;
  logic signed [W-1:0]   diff_sat;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  mi4_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  mi4_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (ram_rdata),
    .den  (p_r),
    .stat (div_stat),
    .quot (div_quot)
  );

  assign div_start = (state_r == S_DIV_WT);

  // Multiply-subtract: the product is floored by the arithmetic shift.
  assign prod_sh = prod_r >>> FRAC_BITS;
  assign diff    = {{(W+1){a_r[W-1]}}, a_r} - {prod_sh[2*W-1], prod_sh};
  always_comb begin
    if (diff > (2*W+1)'(64'sh7FFF_FFFF)) begin
      diff_sat = {1'b0, {(W-1){1'b1}}};
    end else if (diff < -(2*W+1)'(64'sh8000_0000)) begin
      diff_sat = {1'b1, {(W-1){1'b0}}};
    end else begin
      diff_sat = diff[W-1:0];
    end
  end

  // Read address for the RAM, set in the cycle before the registered read data is used.
  always_comb begin
    unique case (state_r)
      S_PIV_RD: ram_raddr = cell_addr(i_r, CW'(i_r));
      S_DIV_RD: ram_raddr = cell_addr(i_r, c_r);
      S_K_RD:   ram_raddr = cell_addr(r_r, CW'(i_r));
      S_V_RD:   ram_raddr = cell_addr(i_r, c_r);
      S_A_RD:   ram_raddr = cell_addr(r_r, c_r);
      S_OUT_RD: ram_raddr = cell_addr(orow_r, CW'(DIM) + CW'(ocol_r));
      default:  ram_raddr = '0;
    endcase
  end

  // Single write port shared by loading, identity fill, division and update.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    unique case (state_r)
      S_LOAD: begin
        ram_we    = in_acc;
        ram_waddr = cell_addr(ld_row_r, CW'(ld_col_r));
        ram_wdata = in_tdata;
      end
      S_IDENT: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(r_r, CW'(DIM) + c_r);
        ram_wdata = (CW'(r_r) == c_r) ? W'(64'd1 << FRAC_BITS) : '0;
      end
      S_DIV_RUN: begin
        ram_we    = div_stat.done;
        ram_waddr = cell_addr(i_r, c_r);
        ram_wdata = div_quot;
      end
      S_MS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(r_r, c_r);
        ram_wdata = diff_sat;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    back_nxt      = back_r;
    ld_row_nxt    = ld_row_r;
    ld_col_nxt    = ld_col_r;
    orow_nxt      = orow_r;
    ocol_nxt      = ocol_r;
    sing_nxt      = sing_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (in_tlast) begin
            ld_row_nxt = '0;
            ld_col_nxt = '0;
            r_nxt      = '0;
            c_nxt      = '0;
            sing_nxt   = 1'b0;
            back_nxt   = 1'b0;
            state_nxt  = S_IDENT;
          end else if (ld_col_r != LAST_I) begin
            ld_col_nxt = ld_col_r + 1'b1;
          end else if (ld_row_r != LAST_I) begin
            ld_col_nxt = '0;
            ld_row_nxt = ld_row_r + 1'b1;
          end
        end
      end
      S_IDENT: begin
        if (c_r != CW'(DIM - 1)) begin
          c_nxt = c_r + 1'b1;
        end else begin
          c_nxt = '0;
          if (r_r != LAST_I) begin
            r_nxt = r_r + 1'b1;
          end else begin
            i_nxt     = '0;
            state_nxt = S_PIV_RD;
          end
        end
      end
      S_PIV_RD: state_nxt = S_PIV_WT;
      S_PIV_WT: begin
        if (ram_rdata == '0) begin
          sing_nxt  = 1'b1;
          orow_nxt  = '0;
          ocol_nxt  = '0;
          state_nxt = S_OUT_RD;
        end else begin
          c_nxt     = LAST_C;
          state_nxt = S_DIV_RD;
        end
      end
      S_DIV_RD: state_nxt = S_DIV_WT;
      S_DIV_WT: state_nxt = S_DIV_RUN;
      S_DIV_RUN: begin
        if (div_stat.done) begin
          if (c_r != '0) begin
            c_nxt     = c_r - 1'b1;
            state_nxt = S_DIV_RD;
          end else if (i_r != LAST_I) begin
            r_nxt     = i_r + 1'b1;
            state_nxt = S_K_RD;
          end else begin
            // Forward pass finished: start clearing above the pivots.
            back_nxt  = 1'b1;
            i_nxt     = LAST_I;
            r_nxt     = IW'(DIM - 2);
            state_nxt = S_K_RD;
          end
        end
      end
      S_K_RD: state_nxt = S_K_WT;
      S_K_WT: begin
        c_nxt     = back_r ? CW'(r_r) : '0;
        state_nxt = S_V_RD;
      end
      S_V_RD: state_nxt = S_A_RD;
      S_A_RD: state_nxt = S_A_WT;
      S_A_WT: state_nxt = S_MS_WR;
      S_MS_WR: begin
        if (c_r != LAST_C) begin
          c_nxt     = c_r + 1'b1;
          state_nxt = S_V_RD;
        end else if (!back_r) begin
          if (r_r != LAST_I) begin
            r_nxt     = r_r + 1'b1;
            state_nxt = S_K_RD;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_PIV_RD;
          end
        end else if (r_r != '0) begin
          r_nxt     = r_r - 1'b1;
          state_nxt = S_K_RD;
        end else if (i_r != IW'(1)) begin
          i_nxt     = i_r - 1'b1;
          r_nxt     = i_r - IW'(2);
          state_nxt = S_K_RD;
        end else begin
          orow_nxt  = '0;
          ocol_nxt  = '0;
          state_nxt = S_OUT_RD;
        end
      end
      S_OUT_RD: state_nxt = S_OUT_WT;
      S_OUT_WT: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = (orow_r == LAST_I) && (ocol_r == LAST_I);
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_LOAD;
          end else begin
            if (ocol_r != LAST_I) begin
              ocol_nxt = ocol_r + 1'b1;
            end else begin
              ocol_nxt = '0;
              orow_nxt = orow_r + 1'b1;
            end
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      i_r         <= '0;
      r_r         <= '0;
      c_r         <= '0;
      back_r      <= 1'b0;
      ld_row_r    <= '0;
      ld_col_r    <= '0;
      orow_r      <= '0;
      ocol_r      <= '0;
      sing_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      r_r         <= r_nxt;
      c_r         <= c_nxt;
      back_r      <= back_nxt;
      ld_row_r    <= ld_row_nxt;
      ld_col_r    <= ld_col_nxt;
      orow_r      <= orow_nxt;
      ocol_r      <= ocol_nxt;
      sing_r      <= sing_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // Datapath registers: pivot, row factor, operands, product, result word.
  always_ff @(posedge clk) begin
    if (state_r == S_PIV_WT) begin
      p_r <= ram_rdata;
    end
    if (state_r == S_K_WT) begin
      k_r <= ram_rdata;
    end
    if (state_r == S_A_RD) begin
      v_r <= ram_rdata;
    end
    if (state_r == S_A_WT) begin
      a_r    <= ram_rdata;
      prod_r <= k_r * v_r;
    end
    if (state_r == S_OUT_WT) begin
      out_data_r <= sing_r ? '0 : ram_rdata;
    end
  end

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = sing_r;

endmodule

FILE: hdl/mi4_checker.sv
// Port-level checker of the matrix inverse unit and its bind.
`include "matrix4_inverse_gauss_jordan_unit_assert.svh"

module mi4_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  `MI4_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "result word changed while stalled")
  `MI4_ASSERT_NOW(a_one_side, clk, rst_n, out_tvalid, !in_tready, "input taken while results pending")
  `MI4_ASSERT_NOW(a_sing_zero, clk, rst_n, out_tvalid && out_tuser, out_tdata == 32'd0, "singular result not zero")
  `MI4_ASSERT_NEXT(a_back_load, clk, rst_n, out_tvalid && out_tready && out_tlast, !out_tvalid && in_tready, "not back to loading after last result")

endmodule

bind matrix4_inverse_gauss_jordan_unit mi4_checker u_mi4_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .in_tlast  (in_tlast),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast),
  .out_tuser (out_tuser)
);
